// ----- sv/eqg_pkg.sv -----
package eqg_pkg;

  typedef enum logic [1:0] {
    KIND_FACE  = 2'd0,
    KIND_PLANE = 2'd1,
    KIND_LINE  = 2'd2,
    KIND_POINT = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [2:0][31:0] p;
    logic [6:0]       s;
    logic             dg;
    logic [2:0]       ng;
  } side_t;

  localparam int unsigned ISQ_STEPS = 32;
  localparam int unsigned DIV_STEPS = 31;

  localparam logic signed [27:0] ONE_Q24  = 28'sd16777216;
  localparam logic signed [27:0] MONE_Q24 = -28'sd16777216;
  localparam logic [55:0]        OFF_MAX  = {56{1'b1}};
  localparam logic [56:0]        AREA_MAX = {57{1'b1}};

endpackage

// ----- sv/eqg_front.sv -----
module eqg_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [1:0]            in_kind,
  input  logic signed [31:0]    in_ax,
  input  logic signed [31:0]    in_ay,
  input  logic signed [31:0]    in_az,
  input  logic signed [31:0]    in_bx,
  input  logic signed [31:0]    in_by,
  input  logic signed [31:0]    in_bz,
  input  logic signed [31:0]    in_cx,
  input  logic signed [31:0]    in_cy,
  input  logic signed [31:0]    in_cz,
  output logic                  v_o,
  output eqg_pkg::side_t        side_o,
  output logic [2:0][30:0]      w_o
);

  logic                v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  eqg_pkg::kind_t      k1_r, k2_r, k3_r, k4_r, k5_r, k6_r;
  logic [2:0][31:0]    a1_r, a2_r, a3_r, a4_r, a5_r, a6_r;
  logic [2:0][31:0]    b1_r, b2_r, c1_r;
  logic signed [65:0]  pr2_r [6];
  logic signed [66:0]  cv3_r [3];
  logic [66:0]         mg4_r [3];
  logic [66:0]         mg5_r [3];
  logic [2:0]          ng4_r, ng5_r, ng6_r;
  logic [6:0]          len5_r;
  logic [2:0][30:0]    w6_r;
  logic [6:0]          s6_r;
  logic                dg6_r;

  logic signed [32:0]  e1 [3];
  logic signed [32:0]  e2 [3];
  logic signed [65:0]  pr_nxt [6];
  logic signed [66:0]  cv_nxt [3];
  logic [66:0]         mg_nxt [3];
  logic [6:0]          len_nxt;
  logic [6:0]          cl;
  logic [97:0]         sh;
  logic [2:0][30:0]    w_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = $signed({b1_r[i][31], b1_r[i]}) - $signed({a1_r[i][31], a1_r[i]});
      e2[i] = $signed({c1_r[i][31], c1_r[i]}) - $signed({a1_r[i][31], a1_r[i]});
    end
    pr_nxt[0] = e1[1] * e2[2];
    pr_nxt[1] = e1[2] * e2[1];
    pr_nxt[2] = e1[2] * e2[0];
    pr_nxt[3] = e1[0] * e2[2];
    pr_nxt[4] = e1[0] * e2[1];
    pr_nxt[5] = e1[1] * e2[0];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (k2_r == eqg_pkg::KIND_FACE) begin
        cv_nxt[i] = 67'(pr2_r[2 * i]) - 67'(pr2_r[2 * i + 1]);
      end else begin
        cv_nxt[i] = 67'($signed(b2_r[i]));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mg_nxt[i] = cv3_r[i][66] ? 67'(-cv3_r[i]) : 67'(cv3_r[i]);
    end
  end

  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      cl = '0;
      for (int b = 0; b < 67; b++) begin
        if (mg4_r[i][b]) begin
          cl = 7'(b + 1);
        end
      end
      if (cl > len_nxt) begin
        len_nxt = cl;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh = {mg5_r[i], 31'b0} >> len5_r;
      w_nxt[i] = sh[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r <= eqg_pkg::kind_t'(in_kind);
      a1_r <= {in_az, in_ay, in_ax};
      b1_r <= {in_bz, in_by, in_bx};
      c1_r <= {in_cz, in_cy, in_cx};
      k2_r <= k1_r;
      a2_r <= a1_r;
      b2_r <= b1_r;
      pr2_r <= pr_nxt;
      k3_r <= k2_r;
      a3_r <= a2_r;
      cv3_r <= cv_nxt;
      k4_r <= k3_r;
      a4_r <= a3_r;
      mg4_r <= mg_nxt;
      for (int i = 0; i < 3; i++) begin
        ng4_r[i] <= cv3_r[i][66];
      end
      k5_r <= k4_r;
      a5_r <= a4_r;
      mg5_r <= mg4_r;
      ng5_r <= ng4_r;
      len5_r <= len_nxt;
      k6_r <= k5_r;
      a6_r <= a5_r;
      ng6_r <= ng5_r;
      w6_r <= w_nxt;
      s6_r <= len5_r - 7'd31;
      dg6_r <= (len5_r == 7'd0);
    end
  end

  assign v_o         = v6_r;
  assign w_o         = w6_r;
  assign side_o.kind = k6_r;
  assign side_o.p    = a6_r;
  assign side_o.s    = s6_r;
  assign side_o.dg   = dg6_r;
  assign side_o.ng   = ng6_r;

endmodule

// ----- sv/eqg_sqrt.sv -----
module eqg_sqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             v_i,
  input  eqg_pkg::side_t   side_i,
  input  logic [2:0][30:0] w_i,
  output logic             v_o,
  output eqg_pkg::side_t   side_o,
  output logic [2:0][30:0] w_o,
  output logic [31:0]      r_o
);

  localparam int unsigned N = eqg_pkg::ISQ_STEPS;

  logic             va_r;
  eqg_pkg::side_t   sda_r;
  logic [2:0][30:0] wa_r;
  logic [61:0]      sqa_r [3];

  logic             v_r   [N + 1];
  eqg_pkg::side_t   sd_r  [N + 1];
  logic [2:0][30:0] w_r   [N + 1];
  logic [63:0]      x_r   [N + 1];
  logic [63:0]      res_r [N + 1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r   <= 1'b0;
      v_r[0] <= 1'b0;
    end else if (adv) begin
      va_r   <= v_i;
      v_r[0] <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sda_r <= side_i;
      wa_r  <= w_i;
      for (int i = 0; i < 3; i++) begin
        sqa_r[i] <= w_i[i] * w_i[i];
      end
      sd_r[0]  <= sda_r;
      w_r[0]   <= wa_r;
      x_r[0]   <= 64'(sqa_r[0]) + 64'(sqa_r[1]) + 64'(sqa_r[2]);
      res_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
    logic [63:0] tr;
    assign tr = res_r[j] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j + 1] <= 1'b0;
      end else if (adv) begin
        v_r[j + 1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[j + 1] <= sd_r[j];
        w_r[j + 1]  <= w_r[j];
        if (x_r[j] >= tr) begin
          x_r[j + 1]   <= x_r[j] - tr;
          res_r[j + 1] <= (res_r[j] >> 1) + BIT;
        end else begin
          x_r[j + 1]   <= x_r[j];
          res_r[j + 1] <= res_r[j] >> 1;
        end
      end
    end
  end

  assign v_o    = v_r[N];
  assign side_o = sd_r[N];
  assign w_o    = w_r[N];
  assign r_o    = res_r[N][31:0];

endmodule

// ----- sv/eqg_div.sv -----
module eqg_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             v_i,
  input  eqg_pkg::side_t   side_i,
  input  logic [2:0][30:0] w_i,
  input  logic [31:0]      r_i,
  output logic             v_o,
  output eqg_pkg::side_t   side_o,
  output logic [2:0][31:0] n_o,
  output logic [31:0]      r_o
);

  localparam int unsigned N = eqg_pkg::DIV_STEPS;

  logic             v_r   [N + 1];
  eqg_pkg::side_t   sd_r  [N + 1];
  logic [31:0]      r_r   [N + 1];
  logic [62:0]      rem_r [N + 1][3];
  logic [30:0]      q_r   [N + 1][3];

  logic             vn_r;
  eqg_pkg::side_t   sdn_r;
  logic [31:0]      rn_r;
  logic [2:0][31:0] n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
      vn_r   <= 1'b0;
    end else if (adv) begin
      v_r[0] <= v_i;
      vn_r   <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_r[0] <= side_i;
      r_r[0]  <= r_i;
      for (int l = 0; l < 3; l++) begin
        rem_r[0][l] <= {2'b0, w_i[l], 30'b0} + 63'(r_i >> 1);
        q_r[0][l]   <= '0;
      end
      sdn_r <= sd_r[N];
      rn_r  <= r_r[N];
      for (int l = 0; l < 3; l++) begin
        n_r[l] <= sd_r[N].ng[l] ? 32'(-{1'b0, q_r[N][l]}) : {1'b0, q_r[N][l]};
      end
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam int unsigned SH = N - 1 - j;
    logic [62:0] d;
    assign d = 63'(r_r[j]) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j + 1] <= 1'b0;
      end else if (adv) begin
        v_r[j + 1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sd_r[j + 1] <= sd_r[j];
        r_r[j + 1]  <= r_r[j];
        for (int l = 0; l < 3; l++) begin
          if (rem_r[j][l] >= d) begin
            rem_r[j + 1][l] <= rem_r[j][l] - d;
            q_r[j + 1][l]   <= q_r[j][l] | (31'd1 << SH);
          end else begin
            rem_r[j + 1][l] <= rem_r[j][l];
            q_r[j + 1][l]   <= q_r[j][l];
          end
        end
      end
    end
  end

  assign v_o    = vn_r;
  assign side_o = sdn_r;
  assign n_o    = n_r;
  assign r_o    = rn_r;

endmodule

// ----- sv/eqg_quad.sv -----
module eqg_quad (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                v_i,
  input  eqg_pkg::side_t      side_i,
  input  logic [2:0][31:0]    n_i,
  input  logic [31:0]         r_i,
  output logic                out_valid,
  output logic signed [25:0]  out_a_xx,
  output logic signed [25:0]  out_a_xy,
  output logic signed [25:0]  out_a_xz,
  output logic signed [25:0]  out_a_yy,
  output logic signed [25:0]  out_a_yz,
  output logic signed [25:0]  out_a_zz,
  output logic signed [47:0]  out_lin_x,
  output logic signed [47:0]  out_lin_y,
  output logic signed [47:0]  out_lin_z,
  output logic [55:0]         out_offset,
  output logic [56:0]         out_tri_area,
  output logic                out_degenerate
);

  localparam int unsigned ROW_OF [6] = '{0, 0, 0, 1, 1, 2};
  localparam int unsigned COL_OF [6] = '{0, 1, 2, 1, 2, 2};

  // stage 1: products
  logic               v1_r;
  eqg_pkg::kind_t     k1_r;
  logic [2:0][31:0]   p1_r;
  logic               dg1_r;
  logic [2:0][31:0]   n1_r;
  logic signed [63:0] pd1_r [3];
  logic [61:0]        nn1_r [6];
  logic [5:0]         nsg1_r;
  logic [63:0]        pp1_r [3];
  logic [56:0]        ar1_r;

  // stage 2: dot products, matrix
  logic               v2_r;
  eqg_pkg::kind_t     k2_r;
  logic [2:0][31:0]   p2_r;
  logic               dg2_r;
  logic [2:0][31:0]   n2_r;
  logic [62:0]        pm2_r;
  logic               psg2_r;
  logic [63:0]        pp2_r;
  logic [56:0]        ar2_r;
  logic [25:0]        a2_r [6];

  // stage 3: partial products
  logic               v3_r;
  eqg_pkg::kind_t     k3_r;
  logic [2:0][31:0]   p3_r;
  logic               dg3_r;
  logic [62:0]        hn3_r [3];
  logic [61:0]        ln3_r [3];
  logic [2:0]         tsg3_r;
  logic [63:0]        hh3_r;
  logic [62:0]        hl3_r;
  logic [61:0]        ll3_r;
  logic [63:0]        pp3_r;
  logic [56:0]        ar3_r;
  logic [25:0]        a3_r [6];

  // stage 4: rounded terms
  logic               v4_r;
  eqg_pkg::kind_t     k4_r;
  logic [2:0][31:0]   p4_r;
  logic               dg4_r;
  logic signed [44:0] t4_r [3];
  logic [58:0]        sq4_r;
  logic [55:0]        pr4_r;
  logic [56:0]        ar4_r;
  logic [25:0]        a4_r [6];

  // output register
  logic               vo_r;
  logic [25:0]        ao_r [6];
  logic [47:0]        lo_r [3];
  logic [55:0]        offo_r;
  logic [56:0]        aro_r;
  logic               dgo_r;

  logic [30:0]        nm [3];
  logic [31:0]        pmag [3];
  logic signed [7:0]  e;
  logic [5:0]         k;
  logic [63:0]        ash;
  logic [71:0]        ard;
  logic [56:0]        ar_nxt;

  logic signed [63:0] pn;
  logic [25:0]        m;
  logic signed [27:0] ms;
  logic signed [27:0] av;
  logic [25:0]        a_nxt [6];

  logic [31:0]        hi3;
  logic [30:0]        lo3;
  logic [30:0]        nm2 [3];

  logic [94:0]        prod4;
  logic [42:0]        tm4;
  logic [126:0]       sqs4;
  logic signed [44:0] t_nxt [3];
  logic [63:0]        prs4;

  logic signed [47:0] t48;
  logic signed [47:0] p48;
  logic [47:0]        lin_nxt [3];
  logic signed [59:0] doff;
  logic [55:0]        off_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      vo_r <= v4_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nm[i]   = n_i[i][31] ? 31'(-n_i[i]) : n_i[i][30:0];
      pmag[i] = side_i.p[i][31] ? (-side_i.p[i]) : side_i.p[i];
    end
    e   = 8'($signed(side_i.s)) - 8'sd9;
    k   = 6'(-e);
    ash = 64'(r_i) << e[4:0];
    ard = (({r_i, 40'b0} >> k) + (72'd1 << 39)) >> 40;
    if (side_i.kind != eqg_pkg::KIND_FACE || side_i.dg) begin
      ar_nxt = '0;
    end else if (e >= 0) begin
      ar_nxt = (ash > 64'(eqg_pkg::AREA_MAX)) ? eqg_pkg::AREA_MAX : ash[56:0];
    end else begin
      ar_nxt = ard[56:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k1_r  <= side_i.kind;
      p1_r  <= side_i.p;
      dg1_r <= side_i.dg;
      n1_r  <= n_i;
      ar1_r <= ar_nxt;
      for (int i = 0; i < 3; i++) begin
        pd1_r[i] <= $signed(side_i.p[i]) * $signed(n_i[i]);
        pp1_r[i] <= pmag[i] * pmag[i];
      end
      for (int i = 0; i < 6; i++) begin
        nn1_r[i]  <= nm[ROW_OF[i]] * nm[COL_OF[i]];
        nsg1_r[i] <= n_i[ROW_OF[i]][31] ^ n_i[COL_OF[i]][31];
      end
    end
  end

  always_comb begin
    pn = pd1_r[0] + pd1_r[1] + pd1_r[2];
    for (int i = 0; i < 6; i++) begin
      m  = 26'((nn1_r[i] + (62'd1 << 35)) >> 36);
      ms = nsg1_r[i] ? -$signed({2'b0, m}) : $signed({2'b0, m});
      unique case (k1_r)
        eqg_pkg::KIND_LINE: begin
          av = ((ROW_OF[i] == COL_OF[i]) ? eqg_pkg::ONE_Q24 : 28'sd0) - ms;
        end
        eqg_pkg::KIND_POINT: begin
          av = (ROW_OF[i] == COL_OF[i]) ? eqg_pkg::ONE_Q24 : 28'sd0;
        end
        default: begin
          av = ms;
        end
      endcase
      if (dg1_r && k1_r != eqg_pkg::KIND_POINT) begin
        av = '0;
      end
      if (av > eqg_pkg::ONE_Q24) begin
        av = eqg_pkg::ONE_Q24;
      end else if (av < eqg_pkg::MONE_Q24) begin
        av = eqg_pkg::MONE_Q24;
      end
      a_nxt[i] = av[25:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k2_r   <= k1_r;
      p2_r   <= p1_r;
      dg2_r  <= dg1_r;
      n2_r   <= n1_r;
      ar2_r  <= ar1_r;
      pm2_r  <= pn[63] ? 63'(-pn) : pn[62:0];
      psg2_r <= pn[63];
      pp2_r  <= pp1_r[0] + pp1_r[1] + pp1_r[2];
      a2_r   <= a_nxt;
    end
  end

  always_comb begin
    hi3 = pm2_r[62:31];
    lo3 = pm2_r[30:0];
    for (int i = 0; i < 3; i++) begin
      nm2[i] = n2_r[i][31] ? 31'(-n2_r[i]) : n2_r[i][30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k3_r  <= k2_r;
      p3_r  <= p2_r;
      dg3_r <= dg2_r;
      ar3_r <= ar2_r;
      pp3_r <= pp2_r;
      a3_r  <= a2_r;
      for (int i = 0; i < 3; i++) begin
        hn3_r[i]  <= hi3 * nm2[i];
        ln3_r[i]  <= lo3 * nm2[i];
        tsg3_r[i] <= psg2_r ^ n2_r[i][31];
      end
      hh3_r <= hi3 * hi3;
      hl3_r <= hi3 * lo3;
      ll3_r <= lo3 * lo3;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod4    = ({32'b0, hn3_r[i]} << 31) + 95'(ln3_r[i]) + (95'd1 << 51);
      tm4      = prod4[94:52];
      t_nxt[i] = tsg3_r[i] ? -$signed({2'b0, tm4}) : $signed({2'b0, tm4});
    end
    sqs4 = ({63'b0, hh3_r} << 62) + ({64'b0, hl3_r} << 32) + 127'(ll3_r)
         + (127'd1 << 67);
    prs4 = (pp3_r + 64'd128) >> 8;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k4_r  <= k3_r;
      p4_r  <= p3_r;
      dg4_r <= dg3_r;
      ar4_r <= ar3_r;
      a4_r  <= a3_r;
      t4_r  <= t_nxt;
      sq4_r <= sqs4[126:68];
      pr4_r <= prs4[55:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t48 = 48'(t4_r[i]);
      p48 = 48'($signed(p4_r[i]));
      unique case (k4_r)
        eqg_pkg::KIND_POINT: lin_nxt[i] = -(p48 <<< 9);
        eqg_pkg::KIND_LINE:  lin_nxt[i] = -(((p48 <<< 8) - t48) <<< 1);
        default:             lin_nxt[i] = -(t48 <<< 1);
      endcase
    end
    doff = $signed({4'b0, pr4_r}) - $signed({1'b0, sq4_r});
    unique case (k4_r)
      eqg_pkg::KIND_POINT: begin
        off_nxt = pr4_r;
      end
      eqg_pkg::KIND_LINE: begin
        if (doff < 0) begin
          off_nxt = '0;
        end else if (doff > $signed({4'b0, eqg_pkg::OFF_MAX})) begin
          off_nxt = eqg_pkg::OFF_MAX;
        end else begin
          off_nxt = doff[55:0];
        end
      end
      default: begin
        off_nxt = (sq4_r > 59'(eqg_pkg::OFF_MAX)) ? eqg_pkg::OFF_MAX : sq4_r[55:0];
      end
    endcase
    if (dg4_r && k4_r != eqg_pkg::KIND_POINT) begin
      off_nxt = '0;
      for (int i = 0; i < 3; i++) begin
        lin_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ao_r   <= a4_r;
      lo_r   <= lin_nxt;
      offo_r <= off_nxt;
      aro_r  <= ar4_r;
      dgo_r  <= dg4_r && (k4_r != eqg_pkg::KIND_POINT);
    end
  end

  assign out_valid      = vo_r;
  assign out_a_xx       = ao_r[0];
  assign out_a_xy       = ao_r[1];
  assign out_a_xz       = ao_r[2];
  assign out_a_yy       = ao_r[3];
  assign out_a_yz       = ao_r[4];
  assign out_a_zz       = ao_r[5];
  assign out_lin_x      = lo_r[0];
  assign out_lin_y      = lo_r[1];
  assign out_lin_z      = lo_r[2];
  assign out_offset     = offo_r;
  assign out_tri_area   = aro_r;
  assign out_degenerate = dgo_r;

endmodule

// ----- sv/error_quadric_generator.sv -----
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    in_kind, in_ax..in_cz
// out      source     out_valid / out_stall  out_a_*, out_lin_*, out_offset,
//                                            out_tri_area, out_degenerate
//
// One transaction per cycle while no held output stalls the pipe.
// The pipe includes the 32-step square-root pipe and the 31-step divider pipe.
// Synchronous active-low reset clears the valid bits only.
// A held output stalls the whole pipe in one step; nothing is dropped.
module error_quadric_generator (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_ax,
  input  logic signed [31:0] in_ay,
  input  logic signed [31:0] in_az,
  input  logic signed [31:0] in_bx,
  input  logic signed [31:0] in_by,
  input  logic signed [31:0] in_bz,
  input  logic signed [31:0] in_cx,
  input  logic signed [31:0] in_cy,
  input  logic signed [31:0] in_cz,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [25:0] out_a_xx,
  output logic signed [25:0] out_a_xy,
  output logic signed [25:0] out_a_xz,
  output logic signed [25:0] out_a_yy,
  output logic signed [25:0] out_a_yz,
  output logic signed [25:0] out_a_zz,
  output logic signed [47:0] out_lin_x,
  output logic signed [47:0] out_lin_y,
  output logic signed [47:0] out_lin_z,
  output logic [55:0]        out_offset,
  output logic [56:0]        out_tri_area,
  output logic               out_degenerate
);

  logic             adv;
  logic             fv, sv, dv;
  eqg_pkg::side_t   fside, sside, dside;
  logic [2:0][30:0] fw, sw;
  logic [31:0]      sr, dr;
  logic [2:0][31:0] dn;

  // advance unless a held result blocks the output register
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  eqg_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_valid(in_valid), .in_kind(in_kind),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az),
    .in_bx(in_bx), .in_by(in_by), .in_bz(in_bz),
    .in_cx(in_cx), .in_cy(in_cy), .in_cz(in_cz),
    .v_o(fv), .side_o(fside), .w_o(fw)
  );

  eqg_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(fv), .side_i(fside), .w_i(fw),
    .v_o(sv), .side_o(sside), .w_o(sw), .r_o(sr)
  );

  eqg_div u_div (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(sv), .side_i(sside), .w_i(sw),
    .r_i(sr), .v_o(dv), .side_o(dside), .n_o(dn), .r_o(dr)
  );

  eqg_quad u_quad (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_i(dv), .side_i(dside), .n_i(dn),
    .r_i(dr), .out_valid(out_valid),
    .out_a_xx(out_a_xx), .out_a_xy(out_a_xy), .out_a_xz(out_a_xz),
    .out_a_yy(out_a_yy), .out_a_yz(out_a_yz), .out_a_zz(out_a_zz),
    .out_lin_x(out_lin_x), .out_lin_y(out_lin_y), .out_lin_z(out_lin_z),
    .out_offset(out_offset), .out_tri_area(out_tri_area),
    .out_degenerate(out_degenerate)
  );

endmodule

// ----- sv/eqg_checker.sv -----
module eqg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_kind,
  input logic signed [31:0] in_ax,
  input logic signed [31:0] in_ay,
  input logic signed [31:0] in_az,
  input logic signed [31:0] in_bx,
  input logic signed [31:0] in_by,
  input logic signed [31:0] in_bz,
  input logic signed [31:0] in_cx,
  input logic signed [31:0] in_cy,
  input logic signed [31:0] in_cz,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [25:0] out_a_xx,
  input logic signed [25:0] out_a_xy,
  input logic signed [25:0] out_a_xz,
  input logic signed [25:0] out_a_yy,
  input logic signed [25:0] out_a_yz,
  input logic signed [25:0] out_a_zz,
  input logic signed [47:0] out_lin_x,
  input logic signed [47:0] out_lin_y,
  input logic signed [47:0] out_lin_z,
  input logic [55:0]        out_offset,
  input logic [56:0]        out_tri_area,
  input logic               out_degenerate
);

  ap_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  ap_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_offset) && $stable(out_lin_x))
    else $error("stalled result changed");

  ap_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  ap_degen: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_offset == 56'd0 && out_tri_area == 57'd0
      && out_a_xx == 26'sd0 && out_a_yy == 26'sd0 && out_a_zz == 26'sd0)
    else $error("degenerate transaction carries a nonzero quadric");

  ap_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_a_xx <= 26'sd16777216 && out_a_xx >= -26'sd16777216)
    else $error("matrix entry out of range");

endmodule

bind error_quadric_generator eqg_checker u_eqg_checker (.*);

// ----- tb/tb_error_quadric_generator.sv -----
`timescale 1ns / 100ps

module tb_error_quadric_generator;

  typedef struct {
    eqg_pkg::kind_t kind;
    int             ax, ay, az, bx, by, bz, cx, cy, cz;
  } geo_t;

  typedef struct packed {
    logic [5:0][25:0] amat;
    logic [47:0]      lin_x;
    logic [47:0]      lin_y;
    logic [47:0]      lin_z;
    logic [55:0]      offset;
    logic [56:0]      tri_area;
    logic             degenerate;
  } qrec_t;

  localparam int ROW_OF[6] = '{0, 0, 0, 1, 1, 2};
  localparam int COL_OF[6] = '{0, 1, 2, 1, 2, 2};
  localparam longint UNIT = 64'sd16777216;
  localparam longint LIN_HI = 64'sd140737488355327;
  localparam int IDLE_LIMIT = 4000;
  localparam int MIN32 = 32'sh80000000;
  localparam int MAX32 = 32'sh7fffffff;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_kind = '0;
  logic signed [31:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [31:0] in_bx = '0, in_by = '0, in_bz = '0;
  logic signed [31:0] in_cx = '0, in_cy = '0, in_cz = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [25:0] out_a_xx, out_a_xy, out_a_xz, out_a_yy, out_a_yz, out_a_zz;
  logic signed [47:0] out_lin_x, out_lin_y, out_lin_z;
  logic [55:0] out_offset;
  logic [56:0] out_tri_area;
  logic out_degenerate;

  qrec_t pending_quadrics[$];
  bit  idle_on = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  int  n_mismatch = 0;
  int  n_checked = 0;
  int  n_degenerate = 0;
  int  n_kind[4] = '{0, 0, 0, 0};

  error_quadric_generator dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [63:0] umag(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint round_shift(longint a, longint b, int k);
    logic [127:0] m;
    m = {64'd0, umag(a)} * {64'd0, umag(b)};
    m = (m + (128'd1 << (k - 1))) >> k;
    if (m > (128'd1 << 60))
      m = 128'd1 << 60;
    return ((a < 0) != (b < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] res, bw;
    res = 0;
    bw = 64'd1 << 62;
    while (bw > x)
      bw = bw >> 2;
    while (bw != 0) begin
      if (x >= res + bw) begin
        x = x - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [127:0] cross_diff(longint a, longint b, longint c,
                                                     longint d);
    logic signed [127:0] x, y, u, v;
    x = a;
    y = b;
    u = c;
    v = d;
    return x * y - u * v;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic qrec_t quadric_of(geo_t g);
    longint p[3], q[3], t[3], e1[3], e2[3], n[3], am[6], lin[3];
    longint off, dotp;
    logic [127:0] m[3], tmp;
    logic signed [127:0] cr[3];
    bit ng[3];
    logic [63:0] w[3], sum, r, pp, area, qv;
    int len, sh, e, k;
    qrec_t res;
    p = '{g.ax, g.ay, g.az};
    q = '{g.bx, g.by, g.bz};
    t = '{g.cx, g.cy, g.cz};
    am = '{0, 0, 0, 0, 0, 0};
    lin = '{0, 0, 0};
    off = 0;
    area = 0;
    res = '0;
    pp = 0;
    for (int i = 0; i < 3; i++)
      pp = pp + umag(p[i]) * umag(p[i]);
    if (g.kind == eqg_pkg::KIND_POINT) begin
      am[0] = UNIT;
      am[3] = UNIT;
      am[5] = UNIT;
      for (int i = 0; i < 3; i++)
        lin[i] = -p[i] * 512;
      off = longint'((pp + 128) >> 8);
    end else begin
      if (g.kind == eqg_pkg::KIND_FACE) begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = q[i] - p[i];
          e2[i] = t[i] - p[i];
        end
        cr[0] = cross_diff(e1[1], e2[2], e1[2], e2[1]);
        cr[1] = cross_diff(e1[2], e2[0], e1[0], e2[2]);
        cr[2] = cross_diff(e1[0], e2[1], e1[1], e2[0]);
        for (int i = 0; i < 3; i++) begin
          ng[i] = cr[i] < 0;
          m[i] = ng[i] ? -cr[i] : cr[i];
        end
      end else begin
        for (int i = 0; i < 3; i++) begin
          ng[i] = q[i] < 0;
          m[i] = {64'd0, umag(q[i])};
        end
      end
      len = 0;
      for (int i = 0; i < 3; i++)
        for (int b = 127; b >= 0; b--)
          if (m[i][b] && b + 1 > len) begin
            len = b + 1;
            break;
          end
      if (len == 0) begin
        res.degenerate = 1'b1;
      end else begin
        sh = len - 31;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          tmp = sh > 0 ? m[i] >> sh : m[i] << (-sh);
          w[i] = tmp[63:0];
          sum = sum + w[i] * w[i];
        end
        r = floor_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          qv = ((w[i] << 30) + (r >> 1)) / r;
          n[i] = ng[i] ? -longint'(qv) : longint'(qv);
        end
        dotp = p[0] * n[0] + p[1] * n[1] + p[2] * n[2];
        if (g.kind == eqg_pkg::KIND_LINE) begin
          for (int i = 0; i < 6; i++)
            am[i] = (ROW_OF[i] == COL_OF[i] ? UNIT : 0)
                    - round_shift(n[ROW_OF[i]], n[COL_OF[i]], 36);
          for (int i = 0; i < 3; i++)
            lin[i] = -2 * (p[i] * 256 - round_shift(dotp, n[i], 52));
          off = longint'((pp + 128) >> 8) - round_shift(dotp, dotp, 68);
        end else begin
          for (int i = 0; i < 6; i++)
            am[i] = round_shift(n[ROW_OF[i]], n[COL_OF[i]], 36);
          for (int i = 0; i < 3; i++)
            lin[i] = -2 * round_shift(dotp, n[i], 52);
          off = round_shift(dotp, dotp, 68);
          if (g.kind == eqg_pkg::KIND_FACE) begin
            e = sh - 9;
            if (e >= 0) begin
              area = r << e;
              if (area > 64'(eqg_pkg::AREA_MAX))
                area = 64'(eqg_pkg::AREA_MAX);
            end else begin
              k = -e;
              area = (r + (64'd1 << (k - 1))) >> k;
            end
          end
        end
      end
    end
    for (int i = 0; i < 6; i++)
      res.amat[i] = 26'(clamp(am[i], -UNIT, UNIT));
    res.lin_x = 48'(clamp(lin[0], -LIN_HI - 1, LIN_HI));
    res.lin_y = 48'(clamp(lin[1], -LIN_HI - 1, LIN_HI));
    res.lin_z = 48'(clamp(lin[2], -LIN_HI - 1, LIN_HI));
    res.offset = 56'(clamp(off, 0, longint'(eqg_pkg::OFF_MAX)));
    res.tri_area = 57'(area);
    return res;
  endfunction

  task automatic send_item(geo_t g);
    int gap;
    gap = idle_on ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= g.kind;
    in_ax <= g.ax; in_ay <= g.ay; in_az <= g.az;
    in_bx <= g.bx; in_by <= g.by; in_bz <= g.bz;
    in_cx <= g.cx; in_cy <= g.cy; in_cz <= g.cz;
    do @(posedge clk); while (in_stall);
    pending_quadrics.insert(pending_quadrics.size(), quadric_of(g));
    n_kind[g.kind]++;
  endtask

  function automatic geo_t make_geo(eqg_pkg::kind_t kd, int ax, int ay, int az, int bx,
                                    int by, int bz, int cx, int cy, int cz);
    geo_t g;
    g = '{kd, ax, ay, az, bx, by, bz, cx, cy, cz};
    return g;
  endfunction

  function automatic int rand_coord(int style);
    case (style)
      0: return int'($urandom);
      1: return $urandom_range(0, 32'h3ffff) - 32'h20000;
      2: return $urandom_range(0, 32'hfff) - 32'h800;
      default: begin
        case ($urandom_range(0, 5))
          0: return MIN32;
          1: return MAX32;
          2: return 0;
          3: return -1;
          4: return 1;
          default: return 32'sh10000;
        endcase
      end
    endcase
  endfunction

  function automatic geo_t rand_geo();
    geo_t g;
    int style;
    style = $urandom_range(0, 3);
    g.kind = eqg_pkg::kind_t'($urandom_range(0, 3));
    g.ax = rand_coord(style); g.ay = rand_coord(style); g.az = rand_coord(style);
    g.bx = rand_coord(style); g.by = rand_coord(style); g.bz = rand_coord(style);
    g.cx = rand_coord(style); g.cy = rand_coord(style); g.cz = rand_coord(style);
    case ($urandom_range(0, 15))
      0: begin
        g.bx = 0; g.by = 0; g.bz = 0;
      end
      1: begin
        g.bx = g.ax; g.by = g.ay; g.bz = g.az;
      end
      2: begin
        g.cx = g.bx; g.cy = g.by; g.cz = g.bz;
      end
      default: ;
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && out_valid && !out_stall) begin
      stall_left = $urandom_range(0, 19);
      out_stall <= (stall_left != 0);
      if (stall_left != 0)
        stall_left = stall_left - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    qrec_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.amat = {out_a_zz, out_a_yz, out_a_yy, out_a_xz, out_a_xy, out_a_xx};
      got.lin_x = out_lin_x;
      got.lin_y = out_lin_y;
      got.lin_z = out_lin_z;
      got.offset = out_offset;
      got.tri_area = out_tri_area;
      got.degenerate = out_degenerate;
      if (pending_quadrics.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("unexpected transaction: %p", got);
      end else begin
        want = pending_quadrics.pop_front();
        n_checked++;
        if (want.degenerate)
          n_degenerate++;
        if (got !== want) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch\n  expected %p\n  actual   %p", want, got);
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("error_quadric_generator test failed");
    $finish;
  end

  task automatic test_directed();
    idle_on = 1'b0;
    send_item(make_geo(eqg_pkg::KIND_FACE, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0));
    send_item(make_geo(eqg_pkg::KIND_FACE, MIN32, MIN32, MIN32, MAX32, MIN32, MIN32,
                       MIN32, MAX32, MAX32));
    send_item(make_geo(eqg_pkg::KIND_FACE, MAX32, MIN32, 0, MIN32, MAX32, MAX32,
                       MIN32, MIN32, MIN32));
    send_item(make_geo(eqg_pkg::KIND_FACE, 5, 5, 5, 5, 5, 5, 5, 5, 5));
    send_item(make_geo(eqg_pkg::KIND_FACE, 0, 0, 0, 1, 1, 1, 2, 2, 2));
    send_item(make_geo(eqg_pkg::KIND_FACE, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_item(make_geo(eqg_pkg::KIND_PLANE, 32'sh30000, -32'sh20000, 7, 0, 0, 32'sh10000,
                       MAX32, MIN32, -1));
    send_item(make_geo(eqg_pkg::KIND_PLANE, MAX32, MAX32, MAX32, 1, 1, 1, 0, 0, 0));
    send_item(make_geo(eqg_pkg::KIND_PLANE, MIN32, MIN32, MIN32, MIN32, MIN32, MIN32,
                       0, 0, 0));
    send_item(make_geo(eqg_pkg::KIND_PLANE, 1, 2, 3, 0, 0, 0, 4, 5, 6));
    send_item(make_geo(eqg_pkg::KIND_PLANE, MAX32, 0, 0, -1, 0, 0, 0, 0, 0));
    send_item(make_geo(eqg_pkg::KIND_LINE, 32'sh10000, 32'sh20000, 0, 0, 0, 32'sh10000,
                       -1, -1, -1));
    send_item(make_geo(eqg_pkg::KIND_LINE, MAX32, MIN32, MAX32, 1, -1, 1, 0, 0, 0));
    send_item(make_geo(eqg_pkg::KIND_LINE, MIN32, MIN32, MIN32, MAX32, MAX32, MAX32,
                       0, 0, 0));
    send_item(make_geo(eqg_pkg::KIND_LINE, 9, 9, 9, 0, 0, 0, 1, 1, 1));
    send_item(make_geo(eqg_pkg::KIND_LINE, 100, 0, 0, 3, 4, 0, 0, 0, 0));
    send_item(make_geo(eqg_pkg::KIND_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(make_geo(eqg_pkg::KIND_POINT, MIN32, MIN32, MIN32, MAX32, 1, 2, 3, 4, 5));
    send_item(make_geo(eqg_pkg::KIND_POINT, MAX32, MAX32, MAX32, 0, 0, 0, 0, 0, 0));
    send_item(make_geo(eqg_pkg::KIND_POINT, -1, 1, 32'sh10000, -1, -1, -1, -1, -1, -1));
  endtask

  task automatic test_random_items(int count);
    idle_on = 1'b1;
    repeat (count) send_item(rand_geo());
  endtask

  task automatic test_back_to_back(int count);
    idle_on = 1'b0;
    repeat (count) send_item(rand_geo());
  endtask

  task automatic test_output_hold(int count);
    idle_on = 1'b0;
    hold_left = 400;
    repeat (count) send_item(rand_geo());
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_items(900);
    test_back_to_back(250);
    test_output_hold(200);
    in_valid <= 1'b0;
    while (pending_quadrics.size() != 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
    $display("checked %0d quadrics (%0d degenerate); faces %0d, planes %0d, lines %0d,",
             n_checked, n_degenerate, n_kind[eqg_pkg::KIND_FACE],
             n_kind[eqg_pkg::KIND_PLANE], n_kind[eqg_pkg::KIND_LINE]);
    $display("points %0d, with random gaps, back-to-back and a long output hold",
             n_kind[eqg_pkg::KIND_POINT]);
    if (n_mismatch == 0 && pending_quadrics.size() == 0)
      $display("error_quadric_generator test passed");
    else
      $display("error_quadric_generator test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/eqg_pkg.sv
sv/eqg_front.sv
sv/eqg_sqrt.sv
sv/eqg_div.sv
sv/eqg_quad.sv
sv/error_quadric_generator.sv
sv/eqg_checker.sv
tb/tb_error_quadric_generator.sv
